>>> sv/hpq_pkg.sv
// Package for the min-heap priority queue: widths, codes, beat and entry types.
`timescale 1ns / 1ps

package hpq_pkg;

   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int OCC_BITS     = 9;
   localparam int DEF_CAPACITY = 256;

   localparam logic KIND_INSERT  = 1'b0;
   localparam logic KIND_EXTRACT = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                    kind;
      logic [KEY_BITS-1:0]     entry_key;
      logic [PAYLOAD_BITS-1:0] entry_payload;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     out_key;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic [1:0]              status;
      logic [OCC_BITS-1:0]     occupancy;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP,
      ST_UP_CMP,
      ST_EX_RD,
      ST_EX_LOAD,
      ST_DN,
      ST_DN_SEL,
      ST_DN_CMP,
      ST_RESP
   } state_type;

endpackage

>>> sv/min_heap_priority_queue_unit.sv
// Top level of the min-heap priority queue: sequencer, comparator and entry store.
//
//   channel  direction  handshake          beat
//   req      in         req_valid/stall    kind, entry_key, entry_payload
//   rsp      out        rsp_valid/stall    out_key, out_payload, status, occupancy
//
// One item at a time. Full insert and empty extract go straight to the response step.
// Each level costs one registered read of the entry store and one pass through the
// single key comparator (two passes going down).
// Reset is synchronous and empties the heap; the store itself is not cleared.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module min_heap_priority_queue_unit #(
   parameter int CAPACITY = hpq_pkg::DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hpq_pkg::rsp_type rsp_data
);
   import hpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   mem_cmd_type         mem_cmd;
   logic [AW-1:0]       wr_addr;
   entry_type           wr_data;
   logic [AW-1:0]       rd_addr_a;
   logic [AW-1:0]       rd_addr_b;
   entry_type           rd_data_a;
   entry_type           rd_data_b;
   logic [KEY_BITS-1:0] cmp_a;
   logic [KEY_BITS-1:0] cmp_b;
   logic                cmp_lt;

   hpq_cmp u_cmp (
      .a_key (cmp_a),
      .b_key (cmp_b),
      .lt    (cmp_lt)
   );

   hpq_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .cmd       (mem_cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   hpq_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_cmd   (mem_cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .cmp_a     (cmp_a),
      .cmp_b     (cmp_b),
      .cmp_lt    (cmp_lt)
   );

endmodule

>>> sv/hpq_ram.sv
// Heap entry store: one write port, two registered read ports.
`timescale 1ns / 1ps

module hpq_ram #(
   parameter int DEPTH = hpq_pkg::DEF_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  hpq_pkg::mem_cmd_type cmd,
   input  logic [AW-1:0]       wr_addr,
   input  hpq_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output hpq_pkg::entry_type  rd_data_a,
   output hpq_pkg::entry_type  rd_data_b
);
   import hpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data between reads
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/hpq_cmp.sv
// Shared key comparator: flags a strictly below b.
`timescale 1ns / 1ps

module hpq_cmp (
   input  logic [hpq_pkg::KEY_BITS-1:0] a_key,
   input  logic [hpq_pkg::KEY_BITS-1:0] b_key,
   output logic                         lt
);
   import hpq_pkg::*;

   assign lt = (a_key < b_key);

endmodule

>>> sv/hpq_seq.sv
// Heap sequencer: sift-up and sift-down walks, entry count and result register.
`timescale 1ns / 1ps

module hpq_seq #(
   parameter int CAPACITY = hpq_pkg::DEF_CAPACITY,
   parameter int AW       = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hpq_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hpq_pkg::rsp_type              rsp_data,
   output hpq_pkg::mem_cmd_type          mem_cmd,
   output logic [AW-1:0]                 wr_addr,
   output hpq_pkg::entry_type            wr_data,
   output logic [AW-1:0]                 rd_addr_a,
   output logic [AW-1:0]                 rd_addr_b,
   input  hpq_pkg::entry_type            rd_data_a,
   input  hpq_pkg::entry_type            rd_data_b,
   output logic [hpq_pkg::KEY_BITS-1:0]  cmp_a,
   output logic [hpq_pkg::KEY_BITS-1:0]  cmp_b,
   input  logic                          cmp_lt
);
   import hpq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = CW + 1;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [IW-1:0]  sel_idx_ff, sel_idx_in;
   entry_type      cur_ff, cur_in;
   entry_type      sel_ff, sel_in;
   entry_type      out_ff, out_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           req_take;
   logic           rsp_free;
   logic           heap_full;
   logic           heap_empty;
   logic [IW-1:0]  count_ext;
   logic [IW-1:0]  child;
   logic [IW-1:0]  child_r;
   logic [IW-1:0]  parent;
   logic [IW-1:0]  idx_m1, child_m1, child_r_m1, parent_m1, last_m1;
   logic           take_right;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign heap_full  = (count_ff == CW'(CAPACITY));
   assign heap_empty = (count_ff == '0);
   assign count_ext  = IW'(count_ff);
   assign child      = {idx_ff[IW-2:0], 1'b0};
   assign child_r    = {idx_ff[IW-2:0], 1'b1};
   assign parent     = idx_ff >> 1;
   assign idx_m1     = idx_ff - IW'(1);
   assign child_m1   = child - IW'(1);
   assign child_r_m1 = child_r - IW'(1);
   assign parent_m1  = parent - IW'(1);
   assign last_m1    = count_ext - IW'(1);
   assign take_right = (child < count_ext) && cmp_lt;

   // shared comparator operands
   always_comb begin
      cmp_a = '0;
      cmp_b = '0;
      case (state_ff)
         ST_UP_CMP: begin
            cmp_a = cur_ff.key;
            cmp_b = rd_data_a.key;
         end
         ST_DN_SEL: begin
            cmp_a = rd_data_b.key;
            cmp_b = rd_data_a.key;
         end
         ST_DN_CMP: begin
            cmp_a = sel_ff.key;
            cmp_b = cur_ff.key;
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_INSERT) begin
                  state_in = heap_full ? ST_RESP : ST_UP;
               end else begin
                  state_in = heap_empty ? ST_RESP : ST_EX_RD;
               end
            end
         end
         ST_UP:      state_in = (idx_ff == IW'(1)) ? ST_RESP : ST_UP_CMP;
         ST_UP_CMP:  state_in = cmp_lt ? ST_UP : ST_RESP;
         ST_EX_RD:   state_in = ST_EX_LOAD;
         ST_EX_LOAD: state_in = ST_DN;
         ST_DN:      state_in = (child <= count_ext) ? ST_DN_SEL : ST_RESP;
         ST_DN_SEL:  state_in = ST_DN_CMP;
         ST_DN_CMP:  state_in = cmp_lt ? ST_DN : ST_RESP;
         ST_RESP:    state_in = rsp_free ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      sel_idx_in   = sel_idx_ff;
      cur_in       = cur_ff;
      sel_in       = sel_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_cmd      = '0;
      wr_addr      = idx_m1[AW-1:0];
      wr_data      = cur_ff;
      rd_addr_a    = parent_m1[AW-1:0];
      rd_addr_b    = child_r_m1[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cur_in    = '{key: req_data.entry_key, payload: req_data.entry_payload};
               out_in    = '0;
               status_in = STATUS_OK;
               if (req_data.kind == KIND_INSERT) begin
                  if (heap_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                     idx_in   = count_ext + IW'(1);
                  end
               end else if (heap_empty) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_UP: begin
            if (idx_ff == IW'(1)) begin
               mem_cmd.wr_en = 1'b1;
            end else begin
               mem_cmd.rd_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            mem_cmd.wr_en = 1'b1;
            if (cmp_lt) begin
               // move the parent down and climb one level
               wr_data = rd_data_a;
               idx_in  = parent;
            end
         end
         ST_EX_RD: begin
            mem_cmd.rd_en = 1'b1;
            rd_addr_a     = '0;
            rd_addr_b     = last_m1[AW-1:0];
         end
         ST_EX_LOAD: begin
            out_in   = rd_data_a;
            cur_in   = rd_data_b;
            count_in = count_ff - CW'(1);
            idx_in   = IW'(1);
         end
         ST_DN: begin
            if (child <= count_ext) begin
               mem_cmd.rd_en = 1'b1;
               rd_addr_a     = child_m1[AW-1:0];
            end else begin
               mem_cmd.wr_en = 1'b1;
            end
         end
         ST_DN_SEL: begin
            // equal keys keep the left child
            sel_in     = take_right ? rd_data_b : rd_data_a;
            sel_idx_in = take_right ? child_r : child;
         end
         ST_DN_CMP: begin
            mem_cmd.wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data = sel_ff;
               idx_in  = sel_idx_ff;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{out_key:     out_ff.key,
                                out_payload: out_ff.payload,
                                status:      status_ff,
                                occupancy:   OCC_BITS'(count_ff)};
            end
         end
         default: begin
            mem_cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      sel_idx_ff <= sel_idx_in;
      cur_ff     <= cur_in;
      sel_ff     <= sel_in;
      out_ff     <= out_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_up_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP || state_ff == ST_UP_CMP) |->
         (idx_ff != '0 && idx_ff <= count_ext))
      else $error("sift-up index outside the heap");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && status_ff == STATUS_FULL) |-> heap_full)
      else $error("full status with room left");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result beat raised outside the response step");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the min-heap priority queue: tracks heap order and checks each result beat.
`timescale 1ns / 1ps

module tb_top;

   import hpq_pkg::*;

   localparam int CAPACITY   = DEF_CAPACITY;
   localparam int HALF_CLOCK = 6;
   localparam int DRAIN_WAIT = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // idle-free stretches: no sender gaps and no receiver stalls
   bit quiet = 1'b0;

   logic [KEY_BITS-1:0]     heap_key [1:CAPACITY];
   logic [PAYLOAD_BITS-1:0] heap_pay [1:CAPACITY];
   int unsigned             heap_count;

   rsp_type     pending_results [$];
   int unsigned mismatch_count = 0;
   int          stall_hold     = 0;

   min_heap_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #(HALF_CLOCK) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Apply one operation to the tracked heap and return the result it should give.
   function automatic rsp_type heap_predict(req_type beat);
      rsp_type                 res;
      int unsigned             pos;
      int unsigned             child;
      logic [KEY_BITS-1:0]     moved_key;
      logic [PAYLOAD_BITS-1:0] moved_pay;
      res = '0;
      if (beat.kind == KIND_INSERT) begin
         if (heap_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            heap_count++;
            pos = heap_count;
            // climb only while strictly smaller than the parent
            while (pos > 1 && beat.entry_key < heap_key[pos / 2]) begin
               heap_key[pos] = heap_key[pos / 2];
               heap_pay[pos] = heap_pay[pos / 2];
               pos = pos / 2;
            end
            heap_key[pos] = beat.entry_key;
            heap_pay[pos] = beat.entry_payload;
            res.status = STATUS_OK;
         end
      end else if (heap_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.out_key     = heap_key[1];
         res.out_payload = heap_pay[1];
         res.status      = STATUS_OK;
         moved_key = heap_key[heap_count];
         moved_pay = heap_pay[heap_count];
         heap_count--;
         pos   = 1;
         child = 2;
         while (child <= heap_count) begin
            // left child wins a tie
            if (child < heap_count && heap_key[child] > heap_key[child + 1]) child++;
            if (moved_key <= heap_key[child]) break;
            heap_key[pos] = heap_key[child];
            heap_pay[pos] = heap_pay[child];
            pos   = child;
            child = child * 2;
         end
         heap_key[pos] = moved_key;
         heap_pay[pos] = moved_pay;
      end
      res.occupancy = heap_count[OCC_BITS-1:0];
      return res;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Leaves valid high after the beat; the next send lowers it only if it waits.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(heap_predict(beat));
   endtask

   // Drop valid so the last beat is not taken again, then wait for every result.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_beat(logic kind, logic [KEY_BITS-1:0] key,
                                         logic [PAYLOAD_BITS-1:0] payload);
      req_type beat;
      beat.kind          = kind;
      beat.entry_key     = key;
      beat.entry_payload = payload;
      return beat;
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_key(int mode);
      case (mode)
         0:       return KEY_BITS'($urandom);
         1:       return KEY_BITS'($urandom_range(0, 15));
         default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      endcase
   endfunction

   function automatic req_type random_beat(int insert_pct, int key_mode);
      logic kind;
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT;
      return make_beat(kind, pick_key(key_mode), $urandom);
   endfunction

   task automatic test_directed();
      send_beat(make_beat(KIND_EXTRACT, '1, '1));
      send_beat(make_beat(KIND_INSERT, '1, '1));
      send_beat(make_beat(KIND_INSERT, '0, '0));
      send_beat(make_beat(KIND_INSERT, 16'h8000, 32'h5555_aaaa));
      send_beat(make_beat(KIND_INSERT, 16'h1234, 32'h0000_0001));
      send_beat(make_beat(KIND_INSERT, 16'h1234, 32'h0000_0002));
      send_beat(make_beat(KIND_INSERT, 16'h1234, 32'h0000_0003));
      send_beat(make_beat(KIND_INSERT, 16'h0001, 32'haaaa_5555));
      send_beat(make_beat(KIND_INSERT, '0, '1));
      for (int n = 0; n < 9; n++)
         send_beat(make_beat(KIND_EXTRACT, KEY_BITS'($urandom), $urandom));
      wait_for_drain();
   endtask

   task automatic test_full();
      for (int n = 0; n < CAPACITY; n++)
         send_beat(make_beat(KIND_INSERT, pick_key(n % 3), $urandom));
      for (int n = 0; n < 3; n++)
         send_beat(make_beat(KIND_INSERT, pick_key(0), $urandom));
      // hold off until every result is back, then drain the heap
      wait_for_drain();
      for (int n = 0; n <= CAPACITY; n++)
         send_beat(make_beat(KIND_EXTRACT, pick_key(0), $urandom));
      wait_for_drain();
   endtask

   task automatic test_random(int unsigned total);
      int unsigned sent;
      int          phase_len;
      int          insert_pct;
      int          key_mode;
      sent = 0;
      while (sent < total) begin
         phase_len = $urandom_range(60, 300);
         case ($urandom_range(0, 3))
            0:       insert_pct = 85;
            1:       insert_pct = 20;
            2:       insert_pct = 50;
            default: insert_pct = 65;
         endcase
         key_mode = $urandom_range(0, 2);
         quiet    = ($urandom_range(0, 5) == 0);
         for (int n = 0; n < phase_len && sent < total; n++) begin
            send_beat(random_beat(insert_pct, key_mode));
            sent++;
         end
         if ($urandom_range(0, 3) == 0) wait_for_drain();
      end
      quiet = 1'b0;
   endtask

   // receiver stalls in runs of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= !quiet && ($urandom_range(0, 3) == 0);
         stall_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: result beat with nothing pending: %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_key", 32'(want.out_key), 32'(rsp_data.out_key));
            check_field("out_payload", 32'(want.out_payload), 32'(rsp_data.out_payload));
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_data.occupancy));
         end
      end
   end

   initial begin
      heap_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full();
      test_random(1216);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("min_heap_priority_queue_unit: match");
      else
         $display("min_heap_priority_queue_unit: mismatch");
      $finish;
   end

   initial begin
      #(30_000_000);
      $display("min_heap_priority_queue_unit: mismatch");
      $finish;
   end

endmodule
